### design/height_field_water_sweep_macros.svh
// assertion macros shared by the checker
`ifndef HEIGHT_FIELD_WATER_SWEEP_MACROS_SVH
`define HEIGHT_FIELD_WATER_SWEEP_MACROS_SVH

// implication checked on every clock, quiet during reset
`define HFW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every clock, quiet during reset
`define HFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/hfw_pkg.sv
package hfw_pkg;
   localparam int GRID_SIZE = 32;
   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW = $clog2(CELLS);
   localparam int IW = $clog2(GRID_SIZE);
   localparam int CW = 5;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_SWEEP = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_BAD   = 2'd3;

   localparam logic CSR_SPRING = 1'b0;
   localparam logic CSR_DAMP   = 1'b1;

   localparam logic [15:0] SPRING_RESET = 16'd6554;
   localparam logic [15:0] DAMP_RESET   = 16'd62259;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_WRITE = 4'd1,
      OP_READ  = 4'd2,
      OP_CLEAR = 4'd3,
      OP_NREAD = 4'd4,
      OP_CREAD = 4'd5,
      OP_CALC1 = 4'd6,
      OP_CALC2 = 4'd7,
      OP_CALC3 = 4'd8,
      OP_STORE = 4'd9
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [AW-1:0]   addr;
      logic [3:0]      nb;
      logic            nb_ok;
      logic            clr_acc;
   } cmd_type;
endpackage

### design/hfw_if.sv
interface hfw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [4:0]  col;
   logic [4:0]  row;
   logic signed [31:0] value;
   modport source (output valid, req_type, col, row, value, input ready);
   modport sink (input valid, req_type, col, row, value, output ready);
endinterface

interface hfw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [31:0] height_out;
   modport source (output valid, status, height_out, input ready);
   modport sink (input valid, status, height_out, output ready);
endinterface

### design/height_field_water_sweep.sv
// Height-field water simulation over a 32 x 32 grid of Q16.16 heights and velocities,
// one request at a time. After reset a clearing pass over all 1024 cells zeroes both
// stores and no request is taken. A sweep visits each cell in turn: eight neighbour
// reads and one cell read on the single read port of the height store, then the gain
// and damping multiply chain. The response is held until taken; the next request is
// accepted once the previous response has been transferred.
module height_field_water_sweep (
   input  logic          clock,
   input  logic          reset,
   hfw_req_if.sink       req,
   hfw_rsp_if.source     rsp,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata
);
   hfw_pkg::cmd_type    cmd;
   logic signed [31:0]  wr_value, rd_height;
   logic [15:0]         spring_ff, damp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spring_ff <= hfw_pkg::SPRING_RESET;
         damp_ff <= hfw_pkg::DAMP_RESET;
      end else if (csr_we) begin
         if (csr_index == hfw_pkg::CSR_SPRING) spring_ff <= csr_wdata;
         if (csr_index == hfw_pkg::CSR_DAMP) damp_ff <= csr_wdata;
      end
   end

   hfw_ctrl u_ctrl (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .rd_height(rd_height), .cmd(cmd), .wr_value(wr_value));
   hfw_datapath u_dp (.clock(clock), .cmd(cmd), .wr_value(wr_value),
      .spring_gain(spring_ff), .damping(damp_ff), .rd_height(rd_height));
endmodule

### design/hfw_ram.sv
module hfw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

### design/hfw_datapath.sv
module hfw_datapath (
   input  logic                  clock,
   input  hfw_pkg::cmd_type      cmd,
   input  logic signed [31:0]    wr_value,
   input  logic [15:0]           spring_gain,
   input  logic [15:0]           damping,
   output logic signed [31:0]    rd_height
);
   logic                   hwe, vwe;
   logic [hfw_pkg::AW-1:0] hraddr, haddr_w;
   logic [31:0]            hwdata, vwdata, hrdata, vrdata;
   logic                   nb_ok_ff;
   logic [3:0]             nb_ff;
   logic signed [40:0]     acc_ff, acc_in;
   logic signed [31:0]     h_ff, v_ff, v2_ff, vn;
   logic signed [33:0]     diff_ff;
   logic signed [50:0]     f_prod_ff;
   logic signed [33:0]     v1;
   logic signed [31:0]     v1_ff;
   logic signed [48:0]     d_prod;
   logic signed [32:0]     hn;
   logic signed [37:0]     avg;

   hfw_ram #(.WIDTH(32), .DEPTH(hfw_pkg::CELLS)) u_h (
      .clock(clock), .we(hwe), .waddr(haddr_w), .wdata(hwdata),
      .raddr(hraddr), .rdata(hrdata));
   hfw_ram #(.WIDTH(32), .DEPTH(hfw_pkg::CELLS)) u_v (
      .clock(clock), .we(vwe), .waddr(cmd.addr), .wdata(vwdata),
      .raddr(cmd.addr), .rdata(vrdata));

   assign hraddr  = cmd.addr;
   assign haddr_w = cmd.addr;

   // store write selection
   always_comb begin
      hwe = 1'b0;
      vwe = 1'b0;
      hwdata = 32'(wr_value);
      vwdata = 32'd0;
      hn = 33'(h_ff) - 33'(v2_ff);
      case (cmd.op)
         hfw_pkg::OP_WRITE: hwe = 1'b1;
         hfw_pkg::OP_CLEAR: begin
            hwe = 1'b1;
            vwe = 1'b1;
            hwdata = 32'd0;
         end
         hfw_pkg::OP_STORE: begin
            hwe = 1'b1;
            vwe = 1'b1;
            vwdata = 32'(v2_ff);
            if (hn > 33'sd2147483647) hwdata = 32'h7fffffff;
            else if (hn < -33'sd2147483648) hwdata = 32'h80000000;
            else hwdata = hn[31:0];
         end
         default: ;
      endcase
   end

   // neighbour accumulation, read data arrives in the cycle after the address
   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr_acc) acc_in = '0;
      else if (nb_ok_ff) acc_in = acc_ff + 41'(signed'(hrdata));
   end

   assign avg = 38'(acc_ff >>> 3);
   assign v1 = 34'(v_ff) - 34'(f_prod_ff >>> 16);
   assign d_prod = v1_ff * $signed({1'b0, damping});
   assign vn = 32'(d_prod >>> 16);

   always_ff @(posedge clock) begin
      nb_ok_ff <= cmd.nb_ok;
      nb_ff <= cmd.nb;
      acc_ff <= acc_in;
      if (cmd.op == hfw_pkg::OP_CALC1) begin
         h_ff <= signed'(hrdata);
         v_ff <= signed'(vrdata);
      end
      if (cmd.op == hfw_pkg::OP_CALC2) diff_ff <= 34'(avg) - 34'(h_ff);
      if (cmd.op == hfw_pkg::OP_CALC3) begin
         f_prod_ff <= 51'(diff_ff * $signed({1'b0, spring_gain}));
      end
      if (cmd.op == hfw_pkg::OP_STORE) ;
      if (cmd.op == hfw_pkg::OP_NONE && nb_ff == 4'd15) ;
   end

   // saturating velocity steps run in the cycles after the gain product
   logic [1:0] vph_ff;
   always_ff @(posedge clock) begin
      vph_ff <= {vph_ff[0], cmd.op == hfw_pkg::OP_CALC3};
      if (vph_ff[0]) begin
         if (v1 > 34'sd2147483647) v1_ff <= 32'sh7fffffff;
         else if (v1 < -34'sd2147483648) v1_ff <= 32'sh80000000;
         else v1_ff <= v1[31:0];
      end
      if (vph_ff[1]) v2_ff <= vn;
   end

   assign rd_height = signed'(hrdata);
endmodule

### design/hfw_ctrl.sv
module hfw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   hfw_req_if.sink              req,
   hfw_rsp_if.source            rsp,
   input  logic signed [31:0]   rd_height,
   output hfw_pkg::cmd_type     cmd,
   output logic signed [31:0]   wr_value
);
   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_RDWT  = 8'b00000100,
      S_NB    = 8'b00001000,
      S_CALC  = 8'b00010000,
      S_STORE = 8'b00100000,
      S_RSP   = 8'b01000000,
      S_RDCAP = 8'b10000000
   } state_type;

   state_type                state_ff, state_in;
   logic [hfw_pkg::AW:0]     cnt_ff, cnt_in;
   logic [hfw_pkg::AW-1:0]   addr_ff, addr_in;
   logic [3:0]               step_ff, step_in;
   logic [1:0]               status_ff, status_in;
   logic signed [31:0]       hout_ff, hout_in;
   logic                     rv_ff, rv_in;
   logic [hfw_pkg::IW-1:0]   r, c;
   logic [1:0]               nb_dr, nb_dc;
   logic signed [hfw_pkg::IW+1:0] nr, nc;
   logic                     on_grid;

   assign r = addr_ff[hfw_pkg::AW-1 -: hfw_pkg::IW];
   assign c = addr_ff[hfw_pkg::IW-1:0];
   assign on_grid = (32'(req.col) < hfw_pkg::GRID_SIZE) && (32'(req.row) < hfw_pkg::GRID_SIZE);
   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.status = status_ff;
   assign rsp.height_out = hout_ff;
   // write data goes to the store in the cycle of the request transfer
   assign wr_value = req.value;

   // row and column offsets for neighbour step 0..7 (centre skipped)
   always_comb begin
      case (step_ff)
         4'd0: {nb_dr, nb_dc} = 4'b0000;
         4'd1: {nb_dr, nb_dc} = 4'b0001;
         4'd2: {nb_dr, nb_dc} = 4'b0010;
         4'd3: {nb_dr, nb_dc} = 4'b0100;
         4'd4: {nb_dr, nb_dc} = 4'b0110;
         4'd5: {nb_dr, nb_dc} = 4'b1000;
         4'd6: {nb_dr, nb_dc} = 4'b1001;
         4'd7: {nb_dr, nb_dc} = 4'b1010;
         default: {nb_dr, nb_dc} = 4'b0101;
      endcase
      nr = $signed({2'b00, r}) + $signed({{hfw_pkg::IW{1'b0}}, nb_dr})
         - $signed((hfw_pkg::IW+2)'(1));
      nc = $signed({2'b00, c}) + $signed({{hfw_pkg::IW{1'b0}}, nb_dc})
         - $signed((hfw_pkg::IW+2)'(1));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      addr_in = addr_ff;
      step_in = step_ff;
      status_in = status_ff;
      hout_in = hout_ff;
      rv_in = rv_ff && !rsp.ready;
      cmd = '0;
      cmd.op = hfw_pkg::OP_NONE;
      cmd.addr = addr_ff;
      case (state_ff)
         // clear both stores after reset
         S_CLEAR: begin
            cmd.op = hfw_pkg::OP_CLEAR;
            cmd.addr = cnt_ff[hfw_pkg::AW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (hfw_pkg::AW+1)'(hfw_pkg::CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               addr_in = hfw_pkg::AW'(32'(req.row) * hfw_pkg::GRID_SIZE + 32'(req.col));
               hout_in = '0;
               status_in = req.req_type;
               case (req.req_type)
                  hfw_pkg::REQ_WRITE: begin
                     if (on_grid) begin
                        cmd.op = hfw_pkg::OP_WRITE;
                        cmd.addr = addr_in;
                     end
                     state_in = S_RSP;
                  end
                  hfw_pkg::REQ_READ: begin
                     if (on_grid) begin
                        cmd.op = hfw_pkg::OP_READ;
                        cmd.addr = addr_in;
                        state_in = S_RDCAP;
                     end else state_in = S_RSP;
                  end
                  hfw_pkg::REQ_SWEEP: begin
                     addr_in = '0;
                     step_in = '0;
                     state_in = S_NB;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_RDCAP: state_in = S_RDWT;
         S_RDWT: begin
            hout_in = rd_height;
            state_in = S_RSP;
         end
         // eight neighbour reads, then the cell itself
         S_NB: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd0) cmd.clr_acc = 1'b1;
            if (step_ff < 4'd8) begin
               cmd.op = hfw_pkg::OP_NREAD;
               cmd.addr = hfw_pkg::AW'(nr) * hfw_pkg::AW'(hfw_pkg::GRID_SIZE) + hfw_pkg::AW'(nc);
               cmd.nb_ok = (nr > 0) && (nr < hfw_pkg::GRID_SIZE - 1)
                        && (nc > 0) && (nc < hfw_pkg::GRID_SIZE - 1);
            end else begin
               cmd.op = hfw_pkg::OP_CREAD;
               step_in = '0;
               state_in = S_CALC;
            end
         end
         // cell read returns, then the arithmetic chain
         S_CALC: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               4'd0: cmd.op = hfw_pkg::OP_CALC1;
               4'd1: cmd.op = hfw_pkg::OP_CALC2;
               4'd2: cmd.op = hfw_pkg::OP_CALC3;
               4'd5: state_in = S_STORE;
               default: ;
            endcase
         end
         S_STORE: begin
            cmd.op = hfw_pkg::OP_STORE;
            step_in = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == hfw_pkg::AW'(hfw_pkg::CELLS - 1)) state_in = S_RSP;
            else state_in = S_NB;
         end
         S_RSP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
      addr_ff <= addr_in;
      step_ff <= step_in;
      status_ff <= status_in;
      hout_ff <= hout_in;
   end
endmodule

### design/hfw_checker.sv
`include "height_field_water_sweep_macros.svh"
module hfw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_height_out
);
   `HFW_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "accept while response pending")
   `HFW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response dropped")
   `HFW_ASSERT_IMP(a_zero_out, clock, reset, rsp_valid && rsp_status != hfw_pkg::REQ_READ, rsp_height_out == 32'd0, "nonzero height on non-read")
   `HFW_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready, "ready right after transfer")
endmodule

bind height_field_water_sweep hfw_checker u_chk (.clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_status(rsp.status), .rsp_height_out(rsp.height_out));
